>>> src/tba_pkg.sv
// Package for the 4-D broadcast adder: element and register widths,
// register indexes, operation codes and the item tag carried down the pipeline.
// No dependencies.
`timescale 1ns / 1ps

package tba_pkg;

  // Element width and configuration register geometry
  localparam int DATA_W    = 32;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 4;
  localparam int NUM_REGS  = 8;
  localparam int NUM_DIMS  = 4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAIN_D0 = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAIN_D1 = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAIN_D2 = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAIN_D3 = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OPND_D0 = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OPND_D1 = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OPND_D2 = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_OPND_D3 = 4'd7;

  // Operation codes of an input item
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_MAIN = 1'b1;

  // What travels with every item through the pipeline
  typedef struct packed {
    logic              is_main;
    logic [DATA_W-1:0] value;
    logic              ok;
    logic              last;
  } tba_tag_t;

endpackage

>>> src/tba_in_if.sv
// Input channel of the broadcast adder: valid/ready plus the item fields.
// Depends on tba_pkg.
`timescale 1ns / 1ps

interface tba_in_if import tba_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     operation;
  logic signed [DATA_W-1:0] element_value;

  modport source (output valid, operation, element_value, input ready);
  modport sink   (input valid, operation, element_value, output ready);
endinterface

>>> src/tba_out_if.sv
// Result channel of the broadcast adder: valid/ready plus the result fields.
// Depends on tba_pkg.
`timescale 1ns / 1ps

interface tba_out_if import tba_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] sum_value;
  logic                     last_element;
  logic                     shape_error;

  modport source (output valid, sum_value, last_element, shape_error, input ready);
  modport sink   (input valid, sum_value, last_element, shape_error, output ready);
endinterface

>>> src/tba_coord.sv
// Front stage: coordinate counters, load pointer and restart flag; turns each
// accepted item into a tag, a starting address and the masked inner coordinates.
// Depends on tba_pkg.
`timescale 1ns / 1ps

module tba_coord import tba_pkg::*; #(
  parameter int OPERAND_DEPTH = 1024,
  parameter int MAX_EXTENT    = 256,
  localparam int EXW = ($clog2(MAX_EXTENT + 1) > CFG_W) ? $clog2(MAX_EXTENT + 1) : CFG_W,
  localparam int CW  = (MAX_EXTENT > 1) ? $clog2(MAX_EXTENT) : 1,
  localparam int AW  = (OPERAND_DEPTH > 1) ? $clog2(OPERAND_DEPTH) : 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_clear,
  input  logic                            shape_ok,
  input  logic [NUM_DIMS-1:0][EXW-1:0]    main_ext,
  input  logic [NUM_DIMS-1:0][EXW-1:0]    opnd_ext,
  input  logic                            up_valid,
  input  logic                            up_op,
  input  logic [DATA_W-1:0]               up_value,
  output logic                            up_ready,
  input  logic                            down_ready,
  output logic                            down_valid,
  output tba_tag_t                        down_tag,
  output logic [AW-1:0]                   down_addr,
  output logic                            down_big,
  output logic [NUM_DIMS-2:0][CW-1:0]     down_crd
);

  localparam int PW  = $clog2(OPERAND_DEPTH + 1);

  logic [NUM_DIMS-1:0][CW-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0]               ptr_r, ptr_nxt;
  logic                        restart_r, restart_nxt;
  logic                        v_r;
  tba_tag_t                    tag_r;
  logic [AW-1:0]               addr_r;
  logic                        big_r;
  logic [NUM_DIMS-2:0][CW-1:0] crd_r;

  logic [NUM_DIMS-1:0][EXW:0]  inc_ext;
  logic [NUM_DIMS-1:0]         wrap, hit, carry;
  logic [NUM_DIMS-1:0][CW-1:0] cb;
  logic [PW-1:0]               base;
  logic                        en, accept, is_main;

  assign en       = !v_r || down_ready;
  assign up_ready = en;
  assign accept   = up_valid && en;
  assign is_main  = (up_op == OP_MAIN);

  // Per-dimension wrap and final-position tests, and broadcast masking
  always_comb begin
    for (int d = 0; d < NUM_DIMS; d++) begin
      inc_ext[d] = (EXW + 1)'(cnt_r[d]) + (EXW + 1)'(1);
      wrap[d]    = inc_ext[d] >= (EXW + 1)'(main_ext[d]);
      hit[d]     = inc_ext[d] == (EXW + 1)'(main_ext[d]);
      cb[d]      = (opnd_ext[d] == EXW'(1)) ? '0 : cnt_r[d];
    end
  end

  // Carry ripples from the innermost dimension outwards
  always_comb begin
    carry[NUM_DIMS-1] = 1'b1;
    for (int d = NUM_DIMS - 2; d >= 0; d--) begin
      carry[d] = carry[d+1] && wrap[d+1];
    end
  end

  // State update for loads, main elements and configuration writes
  always_comb begin
    cnt_nxt     = cnt_r;
    ptr_nxt     = ptr_r;
    restart_nxt = restart_r;
    base        = restart_r ? '0 : ptr_r;
    if (cfg_clear) begin
      cnt_nxt = '0;
    end else if (accept && is_main) begin
      restart_nxt = 1'b1;
      for (int d = 0; d < NUM_DIMS; d++) begin
        if (carry[d]) begin
          cnt_nxt[d] = wrap[d] ? '0 : cnt_r[d] + CW'(1);
        end
      end
    end else if (accept) begin
      restart_nxt = 1'b0;
      ptr_nxt     = (base < PW'(OPERAND_DEPTH)) ? base + PW'(1) : base;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      ptr_r     <= '0;
      restart_r <= 1'b0;
      v_r       <= 1'b0;
    end else begin
      cnt_r     <= cnt_nxt;
      ptr_r     <= ptr_nxt;
      restart_r <= restart_nxt;
      if (en) begin
        v_r <= up_valid;
      end
    end
  end

  // Stage register: a load carries its write address, a main element its
  // outermost coordinate as the start of the address sum
  always_ff @(posedge clk) begin
    if (en) begin
      tag_r.is_main <= is_main;
      tag_r.value   <= up_value;
      tag_r.ok      <= shape_ok;
      tag_r.last    <= &hit;
      for (int j = 0; j < NUM_DIMS - 1; j++) begin
        crd_r[j] <= cb[j+1];
      end
      if (is_main) begin
        addr_r <= AW'(cb[0]);
        big_r  <= 33'(cb[0]) >= 33'(OPERAND_DEPTH);
      end else begin
        addr_r <= AW'(base);
        big_r  <= base >= PW'(OPERAND_DEPTH);
      end
    end
  end

  assign down_valid = v_r;
  assign down_tag   = tag_r;
  assign down_addr  = addr_r;
  assign down_big   = big_r;
  assign down_crd   = crd_r;

endmodule

>>> src/tba_addr.sv
// Address pipeline: one multiply-add per stage builds the row-major operand
// address dimension by dimension; loads pass straight through.
// Depends on tba_pkg.
`timescale 1ns / 1ps

module tba_addr import tba_pkg::*; #(
  parameter int OPERAND_DEPTH = 1024,
  parameter int MAX_EXTENT    = 256,
  localparam int EXW = ($clog2(MAX_EXTENT + 1) > CFG_W) ? $clog2(MAX_EXTENT + 1) : CFG_W,
  localparam int CW  = (MAX_EXTENT > 1) ? $clog2(MAX_EXTENT) : 1,
  localparam int AW  = (OPERAND_DEPTH > 1) ? $clog2(OPERAND_DEPTH) : 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [NUM_DIMS-1:0][EXW-1:0]    opnd_ext,
  input  logic                            up_valid,
  input  tba_tag_t                        up_tag,
  input  logic [AW-1:0]                   up_addr,
  input  logic                            up_big,
  input  logic [NUM_DIMS-2:0][CW-1:0]     up_crd,
  output logic                            up_ready,
  input  logic                            down_ready,
  output logic                            down_valid,
  output tba_tag_t                        down_tag,
  output logic [AW-1:0]                   down_addr,
  output logic                            down_big
);

  localparam int TW   = AW + EXW + 1;
  localparam int NSTG = NUM_DIMS - 1;

  logic [NSTG-1:0]             v_r;
  tba_tag_t                    tag_r  [NSTG];
  logic [AW-1:0]               addr_r [NSTG];
  logic [NSTG-1:0]             big_r;
  logic [NSTG-1:0][CW-1:0]     crd_r  [NSTG];

  logic [NSTG-1:0]             s_v, s_big, en;
  tba_tag_t                    s_tag  [NSTG];
  logic [AW-1:0]               s_addr [NSTG];
  logic [NSTG-1:0][CW-1:0]     s_crd  [NSTG];
  logic [TW-1:0]               prod   [NSTG];

  // Stage inputs: the first stage takes the front stage, the rest their neighbour
  always_comb begin
    s_v[0]    = up_valid;
    s_tag[0]  = up_tag;
    s_addr[0] = up_addr;
    s_big[0]  = up_big;
    s_crd[0]  = up_crd;
    for (int k = 1; k < NSTG; k++) begin
      s_v[k]    = v_r[k-1];
      s_tag[k]  = tag_r[k-1];
      s_addr[k] = addr_r[k-1];
      s_big[k]  = big_r[k-1];
      s_crd[k]  = crd_r[k-1];
    end
  end

  // A stage moves when it is empty or the one after it moves
  always_comb begin
    en[NSTG-1] = !v_r[NSTG-1] || down_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  // Horner step: address times next extent plus next coordinate
  always_comb begin
    for (int k = 0; k < NSTG; k++) begin
      prod[k] = TW'(s_addr[k]) * TW'(opnd_ext[k+1]) + TW'(s_crd[k][k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (en[k]) begin
          v_r[k] <= s_v[k];
        end
      end
    end
  end

  // Past the store depth the address only grows, so one sticky flag suffices
  always_ff @(posedge clk) begin
    for (int k = 0; k < NSTG; k++) begin
      if (en[k]) begin
        tag_r[k] <= s_tag[k];
        crd_r[k] <= s_crd[k];
        if (s_tag[k].is_main) begin
          addr_r[k] <= prod[k][AW-1:0];
          big_r[k]  <= s_big[k] || (prod[k] >= TW'(OPERAND_DEPTH));
        end else begin
          addr_r[k] <= s_addr[k];
          big_r[k]  <= s_big[k];
        end
      end
    end
  end

  assign up_ready   = en[0];
  assign down_valid = v_r[NSTG-1];
  assign down_tag   = tag_r[NSTG-1];
  assign down_addr  = addr_r[NSTG-1];
  assign down_big   = big_r[NSTG-1];

endmodule

>>> src/tba_store.sv
// Operand store with registered read, the add stage and the output register.
// Loads write the store; main elements read it and leave as result items.
// Depends on tba_pkg and tba_out_if.
`timescale 1ns / 1ps

module tba_store import tba_pkg::*; #(
  parameter int OPERAND_DEPTH = 1024,
  localparam int AW = (OPERAND_DEPTH > 1) ? $clog2(OPERAND_DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  input  tba_tag_t         up_tag,
  input  logic [AW-1:0]    up_addr,
  input  logic             up_big,
  output logic             up_ready,
  tba_out_if.source        out_item
);

  logic [DATA_W-1:0] mem [OPERAND_DEPTH];
  logic [DATA_W-1:0] rd_r;
  tba_tag_t          tag_r;
  logic              big_r;
  logic              v_r;
  logic              ov_r;
  logic [DATA_W-1:0] sum_r;
  logic              last_r, err_r;

  logic              en_out, en_rd;
  logic [DATA_W-1:0] opv, sum;

  // Output register frees when empty or taken; a load leaves the read stage freely
  assign en_out   = !ov_r || out_item.ready;
  assign en_rd    = !v_r || !tag_r.is_main || en_out;
  assign up_ready = en_rd;

  // Store access: writes land before any later item reads the same entry
  always_ff @(posedge clk) begin
    if (en_rd) begin
      if (up_valid && !up_tag.is_main && !up_big) begin
        mem[up_addr] <= up_tag.value;
      end
      rd_r  <= mem[up_addr];
      tag_r <= up_tag;
      big_r <= up_big;
    end
  end

  // Address beyond the store reads as zero; on a shape error the element passes
  assign opv = big_r ? '0 : rd_r;
  assign sum = tag_r.ok ? tag_r.value + opv : tag_r.value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r  <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (en_rd) begin
        v_r <= up_valid;
      end
      if (en_out) begin
        ov_r <= v_r && tag_r.is_main;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      sum_r  <= sum;
      last_r <= tag_r.last;
      err_r  <= !tag_r.ok;
    end
  end

  assign out_item.valid        = ov_r;
  assign out_item.sum_value    = sum_r;
  assign out_item.last_element = last_r;
  assign out_item.shape_error  = err_r;

endmodule

>>> src/tensor4d_broadcast_add.sv
// Top level of the streaming 4-D broadcast adder: configuration registers,
// extent saturation and the shape check, and the pipeline of front stage,
// address stages and operand store. Depends on tba_pkg, the interfaces and submodules.
//
//   channel   direction  handshake        payload
//   in_item   in         valid / ready    operation, element_value
//   out_item  out        valid / ready    sum_value, last_element, shape_error
//   cfg_*     in         cfg_we           cfg_index, cfg_data
//
// One item enters per cycle unless the pipeline stalls; a main element passes six
// registers (front stage, three multiply-add address stages, the store read and the
// output register) on its way to the output. Loads take the same path but end at the
// store write. Synchronous active-low reset clears counters, pointer, restart flag and
// all stage valids; the store contents are left as they are. A stalled output holds
// the output register, and stages behind it keep filling until full.
`timescale 1ns / 1ps

module tensor4d_broadcast_add import tba_pkg::*; #(
  parameter int OPERAND_DEPTH = 1024,
  parameter int MAX_EXTENT    = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  tba_in_if.sink               in_item,
  tba_out_if.source            out_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int EXW = ($clog2(MAX_EXTENT + 1) > CFG_W) ? $clog2(MAX_EXTENT + 1) : CFG_W;
  localparam int CW  = (MAX_EXTENT > 1) ? $clog2(MAX_EXTENT) : 1;
  localparam int AW  = (OPERAND_DEPTH > 1) ? $clog2(OPERAND_DEPTH) : 1;
  localparam int RIW = $clog2(NUM_REGS);

  logic [CFG_W-1:0]             cfg_r [NUM_REGS];
  logic [NUM_DIMS-1:0][EXW-1:0] main_ext, opnd_ext;
  logic [NUM_DIMS-1:0]          dim_ok;
  logic                         shape_ok;

  logic                         c_valid, c_ready, c_big;
  tba_tag_t                     c_tag;
  logic [AW-1:0]                c_addr;
  logic [NUM_DIMS-2:0][CW-1:0]  c_crd;
  logic                         a_valid, a_ready, a_big;
  tba_tag_t                     a_tag;
  logic [AW-1:0]                a_addr;

  // Configuration registers; indexes past the list only clear the counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        cfg_r[i] <= CFG_W'(1);
      end
    end else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_REGS))) begin
      cfg_r[cfg_index[RIW-1:0]] <= cfg_data;
    end
  end

  // Extents saturated to 1 .. MAX_EXTENT, and the broadcast check
  always_comb begin
    for (int d = 0; d < NUM_DIMS; d++) begin
      main_ext[d] = EXW'(cfg_r[RIW'(REG_MAIN_D0) + RIW'(d)]);
      opnd_ext[d] = EXW'(cfg_r[RIW'(REG_OPND_D0) + RIW'(d)]);
      if (main_ext[d] == '0) begin
        main_ext[d] = EXW'(1);
      end else if (main_ext[d] > EXW'(MAX_EXTENT)) begin
        main_ext[d] = EXW'(MAX_EXTENT);
      end
      if (opnd_ext[d] == '0) begin
        opnd_ext[d] = EXW'(1);
      end else if (opnd_ext[d] > EXW'(MAX_EXTENT)) begin
        opnd_ext[d] = EXW'(MAX_EXTENT);
      end
      dim_ok[d] = (main_ext[d] == opnd_ext[d]) || (opnd_ext[d] == EXW'(1));
    end
  end

  assign shape_ok = &dim_ok;

  tba_coord #(
    .OPERAND_DEPTH (OPERAND_DEPTH),
    .MAX_EXTENT    (MAX_EXTENT)
  ) u_coord (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_clear  (cfg_we),
    .shape_ok   (shape_ok),
    .main_ext   (main_ext),
    .opnd_ext   (opnd_ext),
    .up_valid   (in_item.valid),
    .up_op      (in_item.operation),
    .up_value   (in_item.element_value),
    .up_ready   (in_item.ready),
    .down_ready (c_ready),
    .down_valid (c_valid),
    .down_tag   (c_tag),
    .down_addr  (c_addr),
    .down_big   (c_big),
    .down_crd   (c_crd)
  );

  tba_addr #(
    .OPERAND_DEPTH (OPERAND_DEPTH),
    .MAX_EXTENT    (MAX_EXTENT)
  ) u_addr (
    .clk        (clk),
    .rst_n      (rst_n),
    .opnd_ext   (opnd_ext),
    .up_valid   (c_valid),
    .up_tag     (c_tag),
    .up_addr    (c_addr),
    .up_big     (c_big),
    .up_crd     (c_crd),
    .up_ready   (c_ready),
    .down_ready (a_ready),
    .down_valid (a_valid),
    .down_tag   (a_tag),
    .down_addr  (a_addr),
    .down_big   (a_big)
  );

  tba_store #(
    .OPERAND_DEPTH (OPERAND_DEPTH)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (a_valid),
    .up_tag   (a_tag),
    .up_addr  (a_addr),
    .up_big   (a_big),
    .up_ready (a_ready),
    .out_item (out_item)
  );

endmodule
